// File: sv/rgbfx_pkg.sv
package rgbfx_pkg;

  localparam int COLOUR_W = 8;
  localparam int PCT_W    = 7;
  localparam int PERIOD_W = 16;
  localparam int ELAPSED_W = 17;
  localparam int SCALE_W  = 14;
  localparam int PROD_W   = 22;
  localparam int DUTY_W   = 8;
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 40;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam int DUTY_DIVISOR = 10000;
  localparam logic [PROD_W-1:0] DIV_TOP = PROD_W'(DUTY_DIVISOR) << (DUTY_W - 1);

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FADE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POWER = 2'd3;

  localparam logic [2:0] REG_FLASH_EN     = 3'd0;
  localparam logic [2:0] REG_PULSE_EN     = 3'd1;
  localparam logic [2:0] REG_FLASH_PERIOD = 3'd2;
  localparam logic [2:0] REG_PULSE_PERIOD = 3'd3;
  localparam logic [2:0] REG_FADE_PERIOD  = 3'd4;
  localparam logic [2:0] REG_BRIGHTNESS   = 3'd5;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [ELAPSED_W-1:0] elapsed_t;

endpackage

// File: sv/rgbfx_mul.sv
module rgbfx_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rgbfx_pkg::SCALE_W-1:0] a,
  input  logic [rgbfx_pkg::DUTY_W-1:0]  b,
  output logic [rgbfx_pkg::PROD_W-1:0]  product,
  output logic                          done
);
  import rgbfx_pkg::*;

  logic [PROD_W-1:0] mcand;
  logic [DUTY_W-1:0] mplier;
  logic [2:0]        cnt;
  logic              busy;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        product <= '0;
        mcand   <= PROD_W'(a);
        mplier  <= b;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/rgbfx_div.sv
module rgbfx_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rgbfx_pkg::PROD_W-1:0] dividend,
  output logic [rgbfx_pkg::DUTY_W-1:0] quotient,
  output logic                         done
);
  import rgbfx_pkg::*;

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dvs;
  logic [2:0]        cnt;
  logic              busy;

  // restoring division by the fixed divisor, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        dvs      <= DIV_TOP;
        quotient <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        if (rem >= dvs) begin
          rem      <= rem - dvs;
          quotient <= {quotient[DUTY_W-2:0], 1'b1};
        end else begin
          quotient <= {quotient[DUTY_W-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/rgb_led_effect_controller.sv
// the result becomes valid once the bit-serial multiplier has run for the level
// product and the multiplier and then the divider have run for each colour channel
// the block takes a new input only in its idle state; a result still waiting holds
// the block in its last state and so holds off the next input transfer
// reset: synchronous, restores the register defaults and clears colour, timers and flags
module rgb_led_effect_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rgbfx_pkg::IN_W-1:0]   s_tdata,  // red, green, blue, power_on
  input  logic [rgbfx_pkg::CMD_W-1:0]  s_tuser,  // cmd
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rgbfx_pkg::OUT_W-1:0]  m_tdata,  // duty_red, duty_green, duty_blue, lit, fading, pulse_level
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rgbfx_pkg::ADDR_W-1:0] paddr,
  input  logic [rgbfx_pkg::DATA_W-1:0] pwdata,
  output logic [rgbfx_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import rgbfx_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LVL_GO   = 3'd1;
  localparam logic [2:0] ST_LVL_WAIT = 3'd2;
  localparam logic [2:0] ST_MUL_GO   = 3'd3;
  localparam logic [2:0] ST_MUL_WAIT = 3'd4;
  localparam logic [2:0] ST_DIV_WAIT = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0] state;
  logic [1:0] ch;

  logic                flash_enable, pulse_enable;
  logic [PERIOD_W-1:0] flash_period, pulse_period, fade_period;
  logic [PCT_W-1:0]    brightness;

  colour_t          current_colour [3];
  colour_t          target_colour  [3];
  logic             led_is_on, fade_flag, level_rising;
  logic [PCT_W-1:0] level_percent;
  elapsed_t         flash_elapsed, pulse_elapsed, fade_elapsed;

  colour_t          current_colour_next [3];
  colour_t          target_colour_next  [3];
  logic             led_is_on_next, fade_flag_next, level_rising_next;
  logic [PCT_W-1:0] level_percent_next;
  elapsed_t         flash_elapsed_next, pulse_elapsed_next, fade_elapsed_next;

  logic [SCALE_W-1:0] scale;
  colour_t            duty [3];

  logic                     mul_start, mul_done, div_start, div_done;
  logic [SCALE_W-1:0]       mul_a;
  logic [DUTY_W-1:0]        mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [DUTY_W-1:0]        div_q;

  logic       s_xfer, wr_en;
  logic [2:0] reg_idx;
  colour_t    in_col [3];
  logic [CMD_W-1:0] cmd;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[4:2];
  assign cmd      = s_tuser;
  assign in_col[0] = s_tdata[7:0];
  assign in_col[1] = s_tdata[15:8];
  assign in_col[2] = s_tdata[23:16];

  function automatic elapsed_t advance(input elapsed_t t);
    advance = (t == ELAPSED_MAX) ? t : t + 17'd1;
  endfunction

  // item update
  always_comb begin
    elapsed_t t;
    logic     same;
    t = '0;
    same = 1'b1;
    for (int i = 0; i < 3; i++) begin
      current_colour_next[i] = current_colour[i];
      target_colour_next[i]  = target_colour[i];
    end
    led_is_on_next     = led_is_on;
    fade_flag_next     = fade_flag;
    level_rising_next  = level_rising;
    level_percent_next = level_percent;
    flash_elapsed_next = flash_elapsed;
    pulse_elapsed_next = pulse_elapsed;
    fade_elapsed_next  = fade_elapsed;
    case (cmd)
      CMD_TICK: begin
        if (flash_enable) begin
          t = advance(flash_elapsed);
          if (t > ELAPSED_W'(flash_period)) begin
            led_is_on_next = ~led_is_on;
            t = '0;
          end
          flash_elapsed_next = t;
        end
        if (pulse_enable) begin
          t = advance(pulse_elapsed);
          if (t > ELAPSED_W'(pulse_period)) begin
            if (level_rising) begin
              if (level_percent < PCT_FULL) begin
                level_percent_next = level_percent + 7'd1;
              end
              if (level_percent_next >= PCT_FULL) begin
                level_percent_next = PCT_FULL;
                level_rising_next  = 1'b0;
              end
            end else begin
              if (level_percent != '0) begin
                level_percent_next = level_percent - 7'd1;
              end
              if (level_percent_next == '0) begin
                level_rising_next = 1'b1;
              end
            end
            t = '0;
          end
          pulse_elapsed_next = t;
        end
        t = advance(fade_elapsed);
        if (led_is_on_next) begin
          for (int i = 0; i < 3; i++) begin
            if (current_colour[i] != target_colour[i]) begin
              same = 1'b0;
            end
          end
          if (same) begin
            fade_flag_next = 1'b0;
          end else begin
            fade_flag_next = 1'b1;
            if (t > ELAPSED_W'(fade_period)) begin
              for (int i = 0; i < 3; i++) begin
                if (target_colour[i] > current_colour[i]) begin
                  current_colour_next[i] = current_colour[i] + 8'd1;
                end else if (target_colour[i] < current_colour[i]) begin
                  current_colour_next[i] = current_colour[i] - 8'd1;
                end
              end
              t = '0;
            end
          end
        end
        fade_elapsed_next = t;
      end
      CMD_SET: begin
        for (int i = 0; i < 3; i++) begin
          current_colour_next[i] = in_col[i];
          target_colour_next[i]  = in_col[i];
        end
      end
      CMD_FADE: begin
        for (int i = 0; i < 3; i++) begin
          target_colour_next[i] = in_col[i];
        end
      end
      CMD_POWER: begin
        led_is_on_next = s_tdata[24];
      end
      default: begin
      end
    endcase
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_enable  <= 1'b0;
      pulse_enable  <= 1'b0;
      flash_period  <= 16'd500;
      pulse_period  <= 16'd50;
      fade_period   <= 16'd1000;
      brightness    <= PCT_FULL;
      for (int i = 0; i < 3; i++) begin
        current_colour[i] <= '0;
        target_colour[i]  <= '0;
      end
      led_is_on     <= 1'b0;
      fade_flag     <= 1'b0;
      level_percent <= PCT_FULL;
      level_rising  <= 1'b0;
      flash_elapsed <= '0;
      pulse_elapsed <= '0;
      fade_elapsed  <= '0;
    end else if (s_xfer) begin
      for (int i = 0; i < 3; i++) begin
        current_colour[i] <= current_colour_next[i];
        target_colour[i]  <= target_colour_next[i];
      end
      led_is_on     <= led_is_on_next;
      fade_flag     <= fade_flag_next;
      level_percent <= level_percent_next;
      level_rising  <= level_rising_next;
      flash_elapsed <= flash_elapsed_next;
      pulse_elapsed <= pulse_elapsed_next;
      fade_elapsed  <= fade_elapsed_next;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FLASH_EN: begin
          flash_enable <= pwdata[0];
          if (pwdata[0]) begin
            flash_elapsed <= '0;
          end
        end
        REG_PULSE_EN: begin
          pulse_enable  <= pwdata[0];
          level_percent <= PCT_FULL;
          if (pwdata[0]) begin
            level_rising  <= 1'b0;
            pulse_elapsed <= '0;
          end
        end
        REG_FLASH_PERIOD: flash_period <= pwdata[15:0];
        REG_PULSE_PERIOD: pulse_period <= pwdata[15:0];
        REG_FADE_PERIOD:  fade_period  <= pwdata[15:0];
        REG_BRIGHTNESS: begin
          brightness <= (pwdata[6:0] > PCT_FULL) ? PCT_FULL : pwdata[6:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLASH_EN:     prdata = DATA_W'(flash_enable);
      REG_PULSE_EN:     prdata = DATA_W'(pulse_enable);
      REG_FLASH_PERIOD: prdata = DATA_W'(flash_period);
      REG_PULSE_PERIOD: prdata = DATA_W'(pulse_period);
      REG_FADE_PERIOD:  prdata = DATA_W'(fade_period);
      REG_BRIGHTNESS:   prdata = DATA_W'(brightness);
      default:          prdata = '0;
    endcase
  end

  // scaling sequencer
  always_comb begin
    mul_start = (state == ST_LVL_GO) || (state == ST_MUL_GO);
    div_start = (state == ST_MUL_WAIT) && mul_done;
    if (state == ST_LVL_GO) begin
      mul_a = SCALE_W'(brightness);
      mul_b = DUTY_W'(level_percent);
    end else begin
      mul_a = scale;
      mul_b = current_colour[ch];
    end
  end

  rgbfx_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  rgbfx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ch       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            state <= ST_LVL_GO;
          end
        end
        ST_LVL_GO: state <= ST_LVL_WAIT;
        ST_LVL_WAIT: begin
          if (mul_done) begin
            scale <= mul_p[SCALE_W-1:0];
            ch    <= '0;
            state <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: state <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            duty[ch] <= led_is_on ? div_q : '0;
            if (ch == 2'd2) begin
              state <= ST_DONE;
            end else begin
              ch    <= ch + 2'd1;
              state <= ST_MUL_GO;
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{(OUT_W - 33){1'b0}}, level_percent, fade_flag, led_is_on,
                         duty[2], duty[1], duty[0]};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/rgb_led_effect_controller_tb.sv
`timescale 1ns / 100ps

module rgb_led_effect_controller_tb;
  import rgbfx_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SEGMENTS    = 10;
  localparam int SEG_ITEMS   = 185;
  localparam int HOLD_LEN    = 400;
  localparam int SETTLE      = 100;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PCT_W-1:0] level;
    logic             fading;
    logic             lit;
    colour_t          blue;
    colour_t          green;
    colour_t          red;
  } led_out_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [2:0]       idx;
    logic [31:0]      val;
    logic [CMD_W-1:0] cmd;
    colour_t          r;
    colour_t          g;
    colour_t          b;
    logic             pwr;
    logic             chk;
    led_out_t         want;
  } stim_row_t;

  localparam led_out_t NO_EXP  = '0;
  localparam led_out_t E_DARK  = '{PCT_FULL, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0};
  localparam led_out_t E_WHITE = '{PCT_FULL, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255};
  localparam led_out_t E_MIXED = '{PCT_FULL, 1'b0, 1'b1, 8'd200, 8'd1, 8'd128};
  localparam led_out_t E_BLACK = '{PCT_FULL, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0};

  localparam int DIR_ROWS = 36;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, E_DARK},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_SET, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, E_DARK},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_POWER, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, E_WHITE},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_POWER, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, E_WHITE},
    '{ROW_WRITE, REG_BRIGHTNESS, 32'hffff_ff7f, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_SET, 8'h80, 8'h01, 8'hc8, 1'b0, 1'b1, E_MIXED},
    '{ROW_WRITE, REG_BRIGHTNESS, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_SET, 8'hff, 8'h00, 8'hff, 1'b0, 1'b1, E_BLACK},
    '{ROW_WRITE, REG_BRIGHTNESS, 32'd50, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_WRITE, REG_FADE_PERIOD, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_FADE, 8'h00, 8'hff, 8'h80, 1'b1, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h55, 8'haa, 8'h55, 1'b1, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'haa, 8'h55, 8'haa, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_WRITE, REG_PULSE_PERIOD, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_WRITE, REG_PULSE_EN, 32'd1, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_WRITE, REG_FLASH_PERIOD, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_WRITE, REG_FLASH_EN, 32'd1, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_POWER, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, NO_EXP},
    '{ROW_WRITE, REG_FLASH_EN, 32'hffff_fffe, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_WRITE, REG_PULSE_EN, 32'h0000_0002, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_WRITE, REG_SPARE_LO, 32'hffff_ffff, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_WRITE, REG_SPARE_HI, 32'h0000_0001, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_WRITE, REG_FLASH_PERIOD, 32'h0000_ffff, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_WRITE, REG_PULSE_PERIOD, 32'hffff_ffff, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_WRITE, REG_FADE_PERIOD, 32'h0000_ffff, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
      NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_POWER, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, NO_EXP},
    '{ROW_ITEM,  3'd0, 32'd0, CMD_SET, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_EXP}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [IN_W-1:0]     s_tdata  = '0;
  logic [CMD_W-1:0]    s_tuser  = CMD_TICK;
  logic                m_tready = 1'b0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [DATA_W-1:0]   pwdata   = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic [OUT_W-1:0]    m_tdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  rgb_led_effect_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // predicted controller state
  logic               fl_en   = 1'b0;
  logic               pu_en   = 1'b0;
  logic [PERIOD_W-1:0] fl_per = 16'd500;
  logic [PERIOD_W-1:0] pu_per = 16'd50;
  logic [PERIOD_W-1:0] fd_per = 16'd1000;
  logic [PCT_W-1:0]   bright  = PCT_FULL;
  colour_t            cur [3] = '{default: '0};
  colour_t            tgt [3] = '{default: '0};
  logic               led_on  = 1'b0;
  logic               fade_flag = 1'b0;
  logic [PCT_W-1:0]   level   = PCT_FULL;
  logic               rising  = 1'b0;
  elapsed_t           fl_cnt  = '0;
  elapsed_t           pu_cnt  = '0;
  elapsed_t           fd_cnt  = '0;

  led_out_t duty_q [$];
  led_out_t typed_by_item [int];
  int       items_sent    = 0;
  int       items_in      = 0;
  int       mismatches    = 0;
  int       cycles        = 0;
  int       send_idle_pct = 17;
  int       recv_idle_pct = 55;
  logic     hold_arm      = 1'b0;
  logic     hold_done     = 1'b0;
  int       hold_left     = 0;
  colour_t  aim [3]       = '{default: '0};

  function automatic elapsed_t elapsed_inc(elapsed_t t);
    return (t == ELAPSED_MAX) ? t : t + 1'b1;
  endfunction

  function automatic led_out_t led_step(logic [CMD_W-1:0] cmd, colour_t r, colour_t g,
                                        colour_t b, logic pwr);
    colour_t  rgb [3];
    logic     same;
    int       d [3];
    led_out_t o;
    rgb[0] = r;
    rgb[1] = g;
    rgb[2] = b;
    case (cmd)
      CMD_TICK: begin
        if (fl_en) begin
          fl_cnt = elapsed_inc(fl_cnt);
          if (fl_cnt > fl_per) begin
            led_on = ~led_on;
            fl_cnt = '0;
          end
        end
        if (pu_en) begin
          pu_cnt = elapsed_inc(pu_cnt);
          if (pu_cnt > pu_per) begin
            if (rising) begin
              if (level < PCT_FULL) level++;
              if (level >= PCT_FULL) begin
                level = PCT_FULL;
                rising = 1'b0;
              end
            end else begin
              if (level > 0) level--;
              if (level == 0) rising = 1'b1;
            end
            pu_cnt = '0;
          end
        end
        fd_cnt = elapsed_inc(fd_cnt);
        if (led_on) begin
          same = 1'b1;
          for (int i = 0; i < 3; i++) if (cur[i] != tgt[i]) same = 1'b0;
          fade_flag = ~same;
          if (!same && fd_cnt > fd_per) begin
            for (int i = 0; i < 3; i++) begin
              if (tgt[i] > cur[i]) cur[i]++;
              else if (tgt[i] < cur[i]) cur[i]--;
            end
            fd_cnt = '0;
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < 3; i++) begin
          tgt[i] = rgb[i];
          cur[i] = rgb[i];
        end
      end
      CMD_FADE: begin
        for (int i = 0; i < 3; i++) tgt[i] = rgb[i];
      end
      default: led_on = pwr;
    endcase
    for (int i = 0; i < 3; i++)
      d[i] = led_on ? (int'(cur[i]) * int'(bright) * int'(level)) / DUTY_DIVISOR : 0;
    o.red    = colour_t'(d[0]);
    o.green  = colour_t'(d[1]);
    o.blue   = colour_t'(d[2]);
    o.lit    = led_on;
    o.fading = fade_flag;
    o.level  = level;
    return o;
  endfunction

  function automatic void led_write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_FLASH_EN: begin
        fl_en = val[0];
        if (fl_en) fl_cnt = '0;
      end
      REG_PULSE_EN: begin
        pu_en = val[0];
        level = PCT_FULL;
        if (pu_en) begin
          rising = 1'b0;
          pu_cnt = '0;
        end
      end
      REG_FLASH_PERIOD: fl_per = val[15:0];
      REG_PULSE_PERIOD: pu_per = val[15:0];
      REG_FADE_PERIOD:  fd_per = val[15:0];
      REG_BRIGHTNESS:   bright = (val[6:0] > PCT_FULL) ? PCT_FULL : val[6:0];
      default: ;
    endcase
  endfunction

  function automatic colour_t rand_chan(colour_t near);
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      2, 3: return near + colour_t'($urandom_range(0, 6)) - 8'd3;
      default: return colour_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_period();
    logic [15:0] lo;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: lo = 16'($urandom_range(0, 4));
      5: lo = 16'hffff;
      6: lo = 16'($urandom);
      default: lo = 16'($urandom_range(5, 40));
    endcase
    return {16'($urandom), lo};
  endfunction

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input logic [CMD_W-1:0] cmd, input colour_t r, input colour_t g,
                           input colour_t b, input logic pwr, input logic chk,
                           input led_out_t want);
    if (chk) typed_by_item[items_sent] = want;
    items_sent++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, pwr, b, g, r};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (duty_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    led_write_reg(idx, val);
    @(posedge clk);
  endtask

  // input transfers feed the predictor
  always @(posedge clk) begin : in_mon
    led_out_t want;
    if (!rst && s_tvalid && s_tready) begin
      want = led_step(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[24]);
      if (typed_by_item.exists(items_in)) want = typed_by_item[items_in];
      duty_q.push_back(want);
      items_in++;
    end
  end

  always @(posedge clk) begin : out_chk
    led_out_t got;
    led_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = led_out_t'(m_tdata[32:0]);
      if (duty_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = duty_q.pop_front();
        cmp_field("duty_red", want.red, got.red);
        cmp_field("duty_green", want.green, got.green);
        cmp_field("duty_blue", want.blue, got.blue);
        cmp_field("lit", 8'(want.lit), 8'(got.lit));
        cmp_field("fading", 8'(want.fading), 8'(got.fading));
        cmp_field("pulse_level", 8'(want.level), 8'(got.level));
        cmp_field("tdata padding", 8'd0, 8'(m_tdata[OUT_W-1:33]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int               k;
    logic [CMD_W-1:0] cmd;
    colour_t          r, g, b;
    logic             pwr;
    logic [6:0]       br;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain();
        reg_write(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        send_item(DIRECTED[i].cmd, DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b,
                  DIRECTED[i].pwr, DIRECTED[i].chk, DIRECTED[i].want);
      end
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      drain();
      if (s < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 55;
      end else if (s < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      reg_write(REG_FLASH_EN, {31'($urandom), 1'($urandom_range(0, 1))});
      reg_write(REG_PULSE_EN, {31'($urandom), 1'($urandom_range(0, 1))});
      reg_write(REG_FLASH_PERIOD, rand_period());
      reg_write(REG_PULSE_PERIOD, rand_period());
      reg_write(REG_FADE_PERIOD, rand_period());
      case ($urandom_range(0, 7))
        0: br = 7'd0;
        1: br = PCT_FULL;
        2: br = 7'($urandom_range(101, 127));
        default: br = 7'($urandom_range(0, 100));
      endcase
      reg_write(REG_BRIGHTNESS, {25'($urandom), br});

      for (int n = 0; n < SEG_ITEMS; n++) begin
        // long receiver hold-off so the block backs up onto its input
        if (s == 6 && n == 5) hold_arm <= 1'b1;
        k   = $urandom_range(0, 99);
        r   = rand_chan(aim[0]);
        g   = rand_chan(aim[1]);
        b   = rand_chan(aim[2]);
        pwr = ($urandom_range(0, 9) < 7);
        if (k < 62) cmd = CMD_TICK;
        else if (k < 76) cmd = CMD_FADE;
        else if (k < 84) cmd = CMD_SET;
        else cmd = CMD_POWER;
        if (cmd == CMD_FADE || cmd == CMD_SET) begin
          aim[0] = r;
          aim[1] = g;
          aim[2] = b;
        end
        send_item(cmd, r, g, b, pwr, 1'b0, NO_EXP);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
